[src/brbio_pkg.sv]
package brbio_pkg;

  localparam int unsigned DEPTH      = 1024;
  localparam int unsigned MAX_BLOCK  = 64;
  localparam int unsigned ADDR_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W      = 11;
  localparam int unsigned LEN_W      = 7;
  localparam int unsigned CMDQ_DEPTH = 4;
  localparam int unsigned CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int unsigned CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);
  localparam int unsigned OUTQ_DEPTH = 4;
  localparam int unsigned OUTQ_AW    = $clog2(OUTQ_DEPTH);
  localparam int unsigned OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

  // function codes
  localparam logic [1:0] FUNC_STRICT_WR = 2'd0;
  localparam logic [1:0] FUNC_OVWR_WR   = 2'd1;
  localparam logic [1:0] FUNC_EXACT_RD  = 2'd2;
  localparam logic [1:0] FUNC_AVAIL_RD  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_NO_DATA  = 2'd2;
  localparam logic [1:0] ST_BAD_LEN  = 2'd3;

  typedef struct packed {
    logic [1:0]       func;
    logic [LEN_W-1:0] block_length;
    logic [7:0]       data_byte;
    logic             first_byte;
    logic             last_byte;
  } item_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             has_data;
    logic             end_of_run;
    logic [1:0]       status;
    logic [LEN_W-1:0] moved_count;
    logic [CNT_W-1:0] used_bytes;
  } result_t;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_STATUS,
    KIND_READ
  } kind_e;

  // One unit of work for the back end. For a read, moved is the run length
  // and used is the fill level before the run.
  typedef struct packed {
    kind_e             kind;
    logic              wr_en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
    logic [1:0]        status;
    logic [LEN_W-1:0]  moved;
    logic [CNT_W-1:0]  used;
  } cmd_t;

  // Step a ring pointer, wrapping at the capacity in use.
  function automatic logic [ADDR_W-1:0] ptr_adv(input logic [ADDR_W-1:0] ptr,
                                                input logic [CNT_W-1:0]  cap);
    logic [CNT_W-1:0] nxt;
    nxt = CNT_W'(ptr) + CNT_W'(1);
    if (nxt >= cap) begin
      return '0;
    end
    return nxt[ADDR_W-1:0];
  endfunction

endpackage

[src/brbio_front.sv]
module brbio_front import brbio_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  item_t            item_i,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  output cmd_t             cmd_o,
  output logic             cmd_valid_o,
  output logic [CNT_W-1:0] capacity_o
);

  logic [CNT_W-1:0]  cap_q, cap_d;
  logic [ADDR_W-1:0] rptr_q, rptr_d, wptr_q, wptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              open_q, open_d, acc_q, acc_d;
  logic [1:0]        bst_q, bst_d;
  logic [LEN_W-1:0]  left_q, left_d, done_q, done_d;

  logic             bad_len;
  logic [CNT_W-1:0] len_w, run_n, rsum;
  cmd_t             cmd;

  assign len_w   = CNT_W'(item_i.block_length);
  assign bad_len = (item_i.block_length == '0) ||
                   (item_i.block_length > LEN_W'(MAX_BLOCK));

  always_comb begin
    cap_d  = cap_q;
    rptr_d = rptr_q;
    wptr_d = wptr_q;
    cnt_d  = cnt_q;
    open_d = open_q;
    acc_d  = acc_q;
    bst_d  = bst_q;
    left_d = left_q;
    done_d = done_q;
    cmd    = '0;
    cmd.kind = KIND_NONE;
    run_n  = '0;
    rsum   = '0;

    if (item_i.func[1]) begin
      // reads
      cmd.used = cnt_q;
      if (bad_len) begin
        cmd.kind   = KIND_STATUS;
        cmd.status = ST_BAD_LEN;
      end else if (len_w > cnt_q && item_i.func == FUNC_EXACT_RD) begin
        cmd.kind   = KIND_STATUS;
        cmd.status = ST_NO_DATA;
      end else begin
        run_n = (len_w > cnt_q) ? cnt_q : len_w;
        if (run_n == '0) begin
          cmd.kind   = KIND_STATUS;
          cmd.status = ST_OK;
        end else begin
          cmd.kind  = KIND_READ;
          cmd.addr  = rptr_q;
          cmd.moved = run_n[LEN_W-1:0];
          cmd.status = ST_OK;
          rsum = CNT_W'(rptr_q) + run_n;
          if (rsum >= cap_q) begin
            rsum = rsum - cap_q;
          end
          rptr_d = rsum[ADDR_W-1:0];
          cnt_d  = cnt_q - run_n;
        end
      end
    end else begin
      // write bytes
      if (item_i.first_byte) begin
        open_d = 1'b1;
        done_d = '0;
        left_d = '0;
        acc_d  = 1'b0;
        if (bad_len) begin
          bst_d = ST_BAD_LEN;
        end else if (item_i.func == FUNC_STRICT_WR && len_w > cap_q - cnt_q) begin
          bst_d = ST_NO_SPACE;
        end else if (item_i.func == FUNC_OVWR_WR && len_w > cap_q) begin
          bst_d = ST_NO_SPACE;
        end else begin
          bst_d  = ST_OK;
          acc_d  = 1'b1;
          left_d = item_i.block_length;
        end
      end

      if (!open_d) begin
        // stray byte
        if (item_i.last_byte) begin
          cmd.kind   = KIND_STATUS;
          cmd.status = ST_BAD_LEN;
          cmd.used   = cnt_q;
        end
      end else begin
        if (acc_d && left_d != '0) begin
          if (cnt_d >= cap_q) begin
            // full: drop the oldest byte
            rptr_d = ptr_adv(rptr_d, cap_q);
            cnt_d  = cnt_d - CNT_W'(1);
          end
          cmd.wr_en = 1'b1;
          cmd.addr  = wptr_q;
          cmd.data  = item_i.data_byte;
          wptr_d = ptr_adv(wptr_q, cap_q);
          cnt_d  = cnt_d + CNT_W'(1);
          left_d = left_d - LEN_W'(1);
          done_d = done_d + LEN_W'(1);
        end
        if (item_i.last_byte) begin
          cmd.kind   = KIND_STATUS;
          cmd.status = bst_d;
          cmd.moved  = done_d;
          cmd.used   = cnt_d;
          open_d = 1'b0;
          acc_d  = 1'b0;
          left_d = '0;
          done_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= CNT_W'(DEPTH);
      rptr_q <= '0;
      wptr_q <= '0;
      cnt_q  <= '0;
      open_q <= 1'b0;
      acc_q  <= 1'b0;
      bst_q  <= ST_OK;
      left_q <= '0;
      done_q <= '0;
    end else if (cfg_we_i) begin
      // clamp capacity and empty the ring
      if (cfg_wdata_i == '0) begin
        cap_q <= CNT_W'(1);
      end else if (cfg_wdata_i > CNT_W'(DEPTH)) begin
        cap_q <= CNT_W'(DEPTH);
      end else begin
        cap_q <= cfg_wdata_i;
      end
      rptr_q <= '0;
      wptr_q <= '0;
      cnt_q  <= '0;
      open_q <= 1'b0;
      acc_q  <= 1'b0;
      bst_q  <= ST_OK;
      left_q <= '0;
      done_q <= '0;
    end else if (accept_i) begin
      cap_q  <= cap_d;
      rptr_q <= rptr_d;
      wptr_q <= wptr_d;
      cnt_q  <= cnt_d;
      open_q <= open_d;
      acc_q  <= acc_d;
      bst_q  <= bst_d;
      left_q <= left_d;
      done_q <= done_d;
    end
  end

  assign cmd_o       = cmd;
  assign cmd_valid_o = cmd.wr_en || (cmd.kind != KIND_NONE);
  assign capacity_o  = cap_q;

endmodule

[src/brbio_cmd_fifo.sv]
module brbio_cmd_fifo import brbio_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t data_o,
  output logic valid_o
);

  cmd_t               mem_q [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] head_q, tail_q;
  logic [CMDQ_CW-1:0] cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == CMDQ_CW'(CMDQ_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[head_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[tail_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        tail_q <= tail_q + CMDQ_AW'(1);
      end
      if (do_pop) begin
        head_q <= head_q + CMDQ_AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CMDQ_CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CMDQ_CW'(1);
      end
    end
  end

endmodule

[src/brbio_back.sv]
module brbio_back import brbio_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  input  logic             cmd_valid_i,
  output logic             cmd_pop_o,
  input  logic [CNT_W-1:0] capacity_i,
  output result_t          result_o,
  output logic             empty_o,
  input  logic             pop_i
);

  logic [7:0]        mem_q [DEPTH];
  logic [7:0]        rd_data_q;

  logic              run_q, run_d;
  logic [ADDR_W-1:0] run_addr_q, run_addr_d;
  logic [LEN_W-1:0]  run_left_q, run_left_d, run_moved_q, run_moved_d;
  logic [CNT_W-1:0]  run_used_q, run_used_d;

  logic              pend_v_q, pend_v_d;
  result_t           pend_q, pend_d;

  result_t           outq_q [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0] ohead_q, otail_q;
  logic [OUTQ_CW-1:0] ocnt_q;

  logic              slot_ok, rd_en, wr_en, need_slot;
  logic              o_push, o_pop;
  result_t           o_entry;

  // a result slot is reserved for the one in the read stage
  assign slot_ok = (ocnt_q + OUTQ_CW'(pend_v_q)) < OUTQ_CW'(OUTQ_DEPTH);
  assign need_slot = (cmd_i.kind != KIND_NONE);

  always_comb begin
    run_d       = run_q;
    run_addr_d  = run_addr_q;
    run_left_d  = run_left_q;
    run_moved_d = run_moved_q;
    run_used_d  = run_used_q;
    pend_v_d    = 1'b0;
    pend_d      = pend_q;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    cmd_pop_o   = 1'b0;

    if (run_q) begin
      if (slot_ok) begin
        rd_en    = 1'b1;
        pend_v_d = 1'b1;
        pend_d.out_byte    = '0;
        pend_d.has_data    = 1'b1;
        pend_d.end_of_run  = (run_left_q == LEN_W'(1));
        pend_d.status      = ST_OK;
        pend_d.moved_count = run_moved_q;
        pend_d.used_bytes  = run_used_q - CNT_W'(1);
        run_used_d = run_used_q - CNT_W'(1);
        run_left_d = run_left_q - LEN_W'(1);
        run_addr_d = ptr_adv(run_addr_q, capacity_i);
        if (run_left_q == LEN_W'(1)) begin
          run_d = 1'b0;
        end
      end
    end else if (cmd_valid_i && (!need_slot || slot_ok)) begin
      cmd_pop_o = 1'b1;
      wr_en     = cmd_i.wr_en;
      case (cmd_i.kind)
        KIND_NONE: begin
        end
        KIND_STATUS: begin
          pend_v_d = 1'b1;
          pend_d.out_byte    = '0;
          pend_d.has_data    = 1'b0;
          pend_d.end_of_run  = 1'b1;
          pend_d.status      = cmd_i.status;
          pend_d.moved_count = cmd_i.moved;
          pend_d.used_bytes  = cmd_i.used;
        end
        KIND_READ: begin
          run_d       = 1'b1;
          run_addr_d  = cmd_i.addr;
          run_left_d  = cmd_i.moved;
          run_moved_d = cmd_i.moved;
          run_used_d  = cmd_i.used;
        end
        default: begin
        end
      endcase
    end
  end

  // byte store, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[cmd_i.addr] <= cmd_i.data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[run_addr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    run_addr_q  <= run_addr_d;
    run_left_q  <= run_left_d;
    run_moved_q <= run_moved_d;
    run_used_q  <= run_used_d;
    pend_q      <= pend_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q    <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      run_q    <= run_d;
      pend_v_q <= pend_v_d;
    end
  end

  // result queue
  always_comb begin
    o_entry = pend_q;
    if (pend_q.has_data) begin
      o_entry.out_byte = rd_data_q;
    end
  end

  assign o_push   = pend_v_q;
  assign empty_o  = (ocnt_q == '0);
  assign o_pop    = pop_i && !empty_o;
  assign result_o = outq_q[ohead_q];

  always_ff @(posedge clk_i) begin
    if (o_push) begin
      outq_q[otail_q] <= o_entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ohead_q <= '0;
      otail_q <= '0;
      ocnt_q  <= '0;
    end else begin
      if (o_push) begin
        otail_q <= otail_q + OUTQ_AW'(1);
      end
      if (o_pop) begin
        ohead_q <= ohead_q + OUTQ_AW'(1);
      end
      if (o_push && !o_pop) begin
        ocnt_q <= ocnt_q + OUTQ_CW'(1);
      end else if (o_pop && !o_push) begin
        ocnt_q <= ocnt_q - OUTQ_CW'(1);
      end
    end
  end

endmodule

[src/byte_ring_buffer_block_io_core.sv]
// Circular byte FIFO with block operations: strict write, overwriting write,
// exact read and read-available, over a 1024-byte store of which the
// capacity register selects how much is in use. Writing the capacity empties
// the ring and closes any open write block; write it only while the block is
// idle. Items enter through push/full and results leave through empty/pop.
// Each write byte is one item; it yields a status result only on the byte
// that closes its block. A read of n bytes is one item that yields n
// results; the back end takes no other command until it has read them all,
// reading the single store read port once a cycle while the result queue has
// room. A status result (refused or empty read, block close) is queued
// by the back end without a store read.
// The store needs no clearing after reset: the fill count keeps every read
// on bytes already written.
module byte_ring_buffer_block_io_core import brbio_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // item side
  input  logic             push,
  output logic             full,
  input  item_t            item_i,
  // result side
  output logic             empty,
  input  logic             pop,
  output result_t          result_o,
  // capacity register
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i
);

  logic             accept;
  cmd_t             f_cmd, q_cmd;
  logic             f_cmd_valid, q_valid, q_full, q_pop;
  logic [CNT_W-1:0] capacity;

  // An item is transferred whenever the command queue has room; the front
  // end keeps all pointer and count state, so it never waits on the back.
  assign accept = push && !q_full;
  assign full   = q_full;

  // front end: classifies each item, tracks pointers, fill count and the
  // open write block, and issues store writes, reads and status results
  brbio_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_o       (f_cmd),
    .cmd_valid_o (f_cmd_valid),
    .capacity_o  (capacity)
  );

  // short command queue decoupling the two ends
  brbio_cmd_fifo u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept && f_cmd_valid),
    .data_i  (f_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_cmd),
    .valid_o (q_valid)
  );

  // back end: owns the store, runs reads byte by byte, queues results
  brbio_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (q_cmd),
    .cmd_valid_i (q_valid),
    .cmd_pop_o   (q_pop),
    .capacity_i  (capacity),
    .result_o    (result_o),
    .empty_o     (empty),
    .pop_i       (pop)
  );

endmodule

[tb/sv/byte_ring_buffer_block_io_core_tb.sv]
module byte_ring_buffer_block_io_core_tb import brbio_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // Run limits, in clk_i cycles.
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 16;   // back end still busy after the last result
  localparam int LONG_HOLD   = 300;  // receiver hold-off used to fill the block

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  // Item side
  logic  push     = 1'b0;
  logic  full;
  item_t item_drv = '0;

  // Result side
  logic    empty;
  logic    pop = 1'b0;
  result_t result_o;

  // Capacity register
  logic             cfg_we    = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;

  always #6 clk_i = ~clk_i;

  byte_ring_buffer_block_io_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .push        (push),
    .full        (full),
    .item_i      (item_drv),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result_o),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Ring predictor. Mirrors the FIFO state and works out the results of every
  // item at the moment its transfer happens.
  // ---------------------------------------------------------------------------
  logic [7:0] ring_mem [DEPTH];
  int         cap_bytes;
  int         fill_level;
  int         rd_idx;
  int         wr_idx;
  bit         blk_open;      // a write block is in progress
  bit         blk_ok;        // open block is being stored
  logic [1:0] blk_status;    // status decided on the first byte
  int         blk_left;      // bytes still allowed into the ring
  int         blk_written;   // bytes stored by the open block

  result_t ring_out_q [$];   // results the block owes, oldest first
  item_t   item_q [$];       // items waiting for the driver

  int err_cnt      = 0;
  int results_seen = 0;
  int rx_hold_req  = 0;      // bumped to ask the receiver for a long hold-off

  function automatic int ring_next(input int idx);
    return (idx + 1 >= cap_bytes) ? 0 : idx + 1;
  endfunction

  // used_bytes always reports the fill level after the result
  task automatic post_result(input logic [7:0] b, input bit has, input bit eor,
                             input logic [1:0] st, input int moved);
    result_t r;
    r.out_byte    = b;
    r.has_data    = has;
    r.end_of_run  = eor;
    r.status      = st;
    r.moved_count = LEN_W'(moved);
    r.used_bytes  = CNT_W'(fill_level);
    ring_out_q.push_back(r);
  endtask

  task automatic ring_set_capacity(input logic [CNT_W-1:0] v);
    if (v == 0) begin
      cap_bytes = 1;
    end else if (v > DEPTH) begin
      cap_bytes = DEPTH;
    end else begin
      cap_bytes = int'(v);
    end
    // capacity write empties the ring and drops any open block
    fill_level  = 0;
    rd_idx      = 0;
    wr_idx      = 0;
    blk_open    = 1'b0;
    blk_ok      = 1'b0;
    blk_status  = ST_OK;
    blk_left    = 0;
    blk_written = 0;
  endtask

  task automatic ring_apply(input item_t it);
    int len;
    int n;
    len = int'(it.block_length);
    if (it.func == FUNC_EXACT_RD || it.func == FUNC_AVAIL_RD) begin
      // reads ignore the write framing bits; an open block stays open
      if (len == 0 || len > MAX_BLOCK) begin
        post_result(8'h00, 1'b0, 1'b1, ST_BAD_LEN, 0);
      end else if (it.func == FUNC_EXACT_RD && len > fill_level) begin
        post_result(8'h00, 1'b0, 1'b1, ST_NO_DATA, 0);
      end else begin
        n = (len > fill_level) ? fill_level : len;
        if (n == 0) begin
          post_result(8'h00, 1'b0, 1'b1, ST_OK, 0);
        end
        for (int i = 0; i < n; i++) begin
          logic [7:0] b;
          b = ring_mem[rd_idx];
          rd_idx = ring_next(rd_idx);
          fill_level--;
          post_result(b, 1'b1, i == n - 1, ST_OK, n);
        end
      end
    end else begin
      if (it.first_byte) begin
        // a new first byte abandons whatever block was open
        blk_open    = 1'b1;
        blk_ok      = 1'b0;
        blk_left    = 0;
        blk_written = 0;
        if (len == 0 || len > MAX_BLOCK) begin
          blk_status = ST_BAD_LEN;
        end else if (it.func == FUNC_STRICT_WR && len > cap_bytes - fill_level) begin
          blk_status = ST_NO_SPACE;
        end else if (it.func == FUNC_OVWR_WR && len > cap_bytes) begin
          blk_status = ST_NO_SPACE;
        end else begin
          blk_status = ST_OK;
          blk_ok     = 1'b1;
          blk_left   = len;
        end
      end
      if (!blk_open) begin
        // stray byte: only a closing one gets a result
        if (it.last_byte) begin
          post_result(8'h00, 1'b0, 1'b1, ST_BAD_LEN, 0);
        end
      end else begin
        if (blk_ok && blk_left > 0) begin
          // full ring: oldest byte goes
          if (fill_level >= cap_bytes) begin
            rd_idx = ring_next(rd_idx);
            fill_level--;
          end
          ring_mem[wr_idx] = it.data_byte;
          wr_idx = ring_next(wr_idx);
          fill_level++;
          blk_left--;
          blk_written++;
        end
        if (it.last_byte) begin
          post_result(8'h00, 1'b0, 1'b1, blk_status, blk_written);
          blk_open    = 1'b0;
          blk_ok      = 1'b0;
          blk_left    = 0;
          blk_written = 0;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of random length, random gaps. An item is predicted at the
  // edge where its transfer happens.
  // ---------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk_i) begin
    if (rst_n) begin
      if (push && !full) begin
        ring_apply(item_drv);
      end
      if (!(push && full)) begin
        if (gap_left > 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (item_q.size() != 0) begin
          item_drv <= item_q.pop_front();
          push     <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            // about one burst in four runs straight into the next
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each result transfer against the oldest prediction and
  // runs its own on/off stall pattern, plus the long hold-off on request.
  // ---------------------------------------------------------------------------
  int rx_on_left  = 0;
  int rx_off_left = 0;
  int hold_left   = 0;
  int hold_seen   = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_cnt++;
    $display("MISMATCH result %0d %s: got %0h want %0h", results_seen, what, got, want);
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_n) begin
      if (pop && !empty) begin
        if (ring_out_q.size() == 0) begin
          report_mismatch("unexpected result", 32'(result_o), 32'd0);
        end else begin
          want = ring_out_q.pop_front();
          if (result_o.out_byte !== want.out_byte)
            report_mismatch("out_byte", 32'(result_o.out_byte), 32'(want.out_byte));
          if (result_o.has_data !== want.has_data)
            report_mismatch("has_data", 32'(result_o.has_data), 32'(want.has_data));
          if (result_o.end_of_run !== want.end_of_run)
            report_mismatch("end_of_run", 32'(result_o.end_of_run),
                            32'(want.end_of_run));
          if (result_o.status !== want.status)
            report_mismatch("status", 32'(result_o.status), 32'(want.status));
          if (result_o.moved_count !== want.moved_count)
            report_mismatch("moved_count", 32'(result_o.moved_count),
                            32'(want.moved_count));
          if (result_o.used_bytes !== want.used_bytes)
            report_mismatch("used_bytes", 32'(result_o.used_bytes),
                            32'(want.used_bytes));
        end
        results_seen++;
      end

      if (rx_hold_req != hold_seen) begin
        hold_seen = rx_hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (rx_on_left > 0) begin
        rx_on_left--;
        pop <= 1'b1;
      end else if (rx_off_left > 0) begin
        rx_off_left--;
        pop <= 1'b0;
      end else begin
        // occasional long ready stretches between short on/off windows
        rx_on_left  = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
        rx_off_left = $urandom_range(0, 5);
        pop <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_item(input logic [1:0] f, input int len, input logic [7:0] d,
                          input bit fb, input bit lb);
    item_t it;
    it.func         = f;
    it.block_length = LEN_W'(len);
    it.data_byte    = d;
    it.first_byte   = fb;
    it.last_byte    = lb;
    item_q.push_back(it);
  endtask

  // nbytes items of one block, length declared on the first
  task automatic add_block(input logic [1:0] f, input int len, input int nbytes);
    for (int i = 0; i < nbytes; i++) begin
      add_item(f, len, 8'($urandom), i == 0, i == nbytes - 1);
    end
  endtask

  // framing bits and data are noise on a read
  task automatic add_read(input logic [1:0] f, input int len);
    add_item(f, len, 8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // sender stops; wait for every owed result, then let the back end settle
  task automatic wait_drained();
    while (item_q.size() != 0 || push || ring_out_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CNT_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    ring_set_capacity(v);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly well-formed blocks and reads; the rest short, overlong, bad
  // length, abandoned or stray. Ignored stray bytes do not count.
  task automatic gen_traffic(input int budget);
    int         made;
    int         kind;
    int         len;
    int         n;
    logic [1:0] wf;
    logic [1:0] rf;
    made = 0;
    while (made < budget) begin
      kind = $urandom_range(0, 99);
      wf   = $urandom_range(0, 1) ? FUNC_OVWR_WR : FUNC_STRICT_WR;
      if (kind < 45) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        add_block(wf, len, len);
        made += len;
      end else if (kind < 75) begin
        rf = $urandom_range(0, 1) ? FUNC_AVAIL_RD : FUNC_EXACT_RD;
        n  = $urandom_range(0, 19);
        if (n == 0) begin
          len = 0;
        end else if (n == 1) begin
          len = $urandom_range(MAX_BLOCK + 1, 127);
        end else if (n < 5) begin
          len = $urandom_range(9, MAX_BLOCK);
        end else begin
          len = $urandom_range(1, 8);
        end
        add_read(rf, len);
        made++;
      end else if (kind < 82) begin
        // short block: closed early
        len = $urandom_range(2, 12);
        n   = $urandom_range(1, len - 1);
        add_block(wf, len, n);
        made += n;
      end else if (kind < 88) begin
        // excess bytes past the declared length
        len = $urandom_range(1, 4);
        n   = len + $urandom_range(1, 3);
        add_block(wf, len, n);
        made += n;
      end else if (kind < 93) begin
        len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(MAX_BLOCK + 1, 127);
        n   = $urandom_range(1, 3);
        add_block(wf, len, n);
        made += n;
      end else if (kind < 97) begin
        // opened and left open; whatever follows continues or abandons it
        len = $urandom_range(2, 8);
        n   = $urandom_range(1, len - 1);
        for (int i = 0; i < n; i++) begin
          add_item(wf, len, 8'($urandom), i == 0, 1'b0);
        end
        made += n;
      end else begin
        n = $urandom_range(0, 1);
        add_item(wf, $urandom_range(0, 127), 8'($urandom), 1'b0, n != 0);
        made += n;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------
  int cycle_cnt = 0;

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("byte_ring_buffer_block_io_core test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    logic [CNT_W-1:0] caps [6];
    caps[0] = 11'd0;      // clamps to one byte
    caps[1] = 11'd2;
    caps[2] = 11'd7;
    caps[3] = 11'd2047;   // clamps to the full store
    caps[4] = 11'd1024;
    caps[5] = CNT_W'($urandom_range(3, 40));

    ring_set_capacity(CNT_W'(DEPTH));
    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Directed pass at reset capacity
    add_read(FUNC_EXACT_RD, 4);            // empty ring: not enough data
    add_read(FUNC_AVAIL_RD, 3);            // empty ring: empty read, ok
    add_read(FUNC_EXACT_RD, 0);            // zero length
    add_read(FUNC_AVAIL_RD, 127);          // over the limit, all length bits high
    add_block(FUNC_STRICT_WR, 2, 2);
    add_item(FUNC_OVWR_WR, 1, 8'hFF, 1'b1, 1'b1);
    add_item(FUNC_STRICT_WR, 1, 8'h00, 1'b1, 1'b1);
    add_read(FUNC_AVAIL_RD, MAX_BLOCK);    // asks for more than stored
    add_item(FUNC_OVWR_WR, 5, 8'($urandom), 1'b0, 1'b1);    // stray closing byte
    add_item(FUNC_STRICT_WR, 5, 8'($urandom), 1'b0, 1'b0);  // stray, ignored
    add_block(FUNC_STRICT_WR, 0, 1);       // zero-length block
    add_block(FUNC_OVWR_WR, MAX_BLOCK + 1, 2);
    add_block(FUNC_STRICT_WR, MAX_BLOCK, 2);  // max length, closed short
    add_block(FUNC_OVWR_WR, 1, 3);         // bytes past the length dropped
    add_item(FUNC_STRICT_WR, 3, 8'($urandom), 1'b1, 1'b0);
    add_read(FUNC_EXACT_RD, 1);            // read while a block is open
    add_item(FUNC_STRICT_WR, 3, 8'($urandom), 1'b0, 1'b0);
    add_block(FUNC_OVWR_WR, 1, 1);         // abandons the open block
    add_read(FUNC_EXACT_RD, 3);
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      write_capacity(caps[p]);
      if (p == 2) begin
        // sender waits out every owed result mid-phase
        gen_traffic(6);
        wait_drained();
        gen_traffic(6);
      end else if (p == 3) begin
        // receiver holds off while the sender keeps offering: block fills up
        rx_hold_req++;
        gen_traffic(24);
      end else begin
        gen_traffic(12);
      end
      wait_drained();
    end

    if (err_cnt == 0 && ring_out_q.size() == 0) begin
      $display("byte_ring_buffer_block_io_core test passed");
    end else begin
      $display("byte_ring_buffer_block_io_core test failed");
    end
    $finish;
  end

endmodule

[files.f]
src/brbio_pkg.sv
src/brbio_front.sv
src/brbio_cmd_fifo.sv
src/brbio_back.sv
src/byte_ring_buffer_block_io_core.sv
tb/sv/byte_ring_buffer_block_io_core_tb.sv
